// ===== hw/rtl/bfd_pkg.sv =====
// Package for the barycentric weight pipeline: field widths, word types,
// partial-product helpers for the wide multiplies. No dependencies.
package bfd_pkg;

	localparam int COORD_BITS  = 16;
	localparam int FRAC_BITS   = 16;
	localparam int WEIGHT_BITS = FRAC_BITS + 4;
	localparam int EDGE_W      = COORD_BITS + 1;
	localparam int PROD_W      = 2 * EDGE_W;
	localparam int DOT_W       = PROD_W + 2;
	localparam int HALF_W      = DOT_W / 2;
	localparam int PP_W        = 2 * (HALF_W + 1);
	localparam int MUL_W       = 2 * DOT_W;
	localparam int GRAM_W      = MUL_W + 1;
	localparam int REM_W       = GRAM_W + 4;
	localparam int Q_W         = FRAC_BITS + 3;
	localparam int DIV_STEPS   = FRAC_BITS + 4;

	localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
	localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
	localparam logic signed [WEIGHT_BITS-1:0] W_ONE = WEIGHT_BITS'(1) << FRAC_BITS;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vert_a_x;
		logic signed [COORD_BITS-1:0] vert_a_y;
		logic signed [COORD_BITS-1:0] vert_a_z;
		logic signed [COORD_BITS-1:0] vert_b_x;
		logic signed [COORD_BITS-1:0] vert_b_y;
		logic signed [COORD_BITS-1:0] vert_b_z;
		logic signed [COORD_BITS-1:0] vert_c_x;
		logic signed [COORD_BITS-1:0] vert_c_y;
		logic signed [COORD_BITS-1:0] vert_c_z;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_z;
	} in_t;

	typedef struct packed {
		logic signed [WEIGHT_BITS-1:0] weight_a;
		logic signed [WEIGHT_BITS-1:0] weight_b;
		logic signed [WEIGHT_BITS-1:0] weight_c;
		logic                          degenerate;
	} out_t;

	typedef logic signed [DOT_W-1:0] dot_t;

	typedef struct packed {
		dot_t d00;
		dot_t d01;
		dot_t d11;
		dot_t d20;
		dot_t d21;
	} dots_t;

	typedef struct packed {
		logic signed [GRAM_W-1:0] den;
		logic signed [GRAM_W-1:0] nb;
		logic signed [GRAM_W-1:0] nc;
	} gram_t;

	typedef struct packed {
		logic [GRAM_W-1:0] d;
		logic [REM_W-1:0]  rb;
		logic [REM_W-1:0]  rc;
		logic [Q_W-1:0]    qb;
		logic [Q_W-1:0]    qc;
		logic              satb;
		logic              satc;
		logic              negb;
		logic              negc;
		logic              degen;
	} quot_t;

	typedef logic [3:0][PP_W-1:0] pp4_t;

	// Split both operands into a signed high half and an unsigned low half.
	function automatic pp4_t part_mul(dot_t a, dot_t b);
		logic signed [HALF_W:0] ah, al, bh, bl;
		pp4_t r;
		ah = {a[DOT_W-1], a[DOT_W-1 -: HALF_W]};
		al = {1'b0, a[HALF_W-1:0]};
		bh = {b[DOT_W-1], b[DOT_W-1 -: HALF_W]};
		bl = {1'b0, b[HALF_W-1:0]};
		r[0] = al * bl;
		r[1] = al * bh;
		r[2] = ah * bl;
		r[3] = ah * bh;
		return r;
	endfunction

	function automatic logic signed [MUL_W-1:0] join_mul(pp4_t p);
		logic signed [MUL_W-1:0] s;
		s = MUL_W'($signed(p[0]))
			+ (MUL_W'($signed(p[1])) << HALF_W)
			+ (MUL_W'($signed(p[2])) << HALF_W)
			+ (MUL_W'($signed(p[3])) << (2 * HALF_W));
		return s;
	endfunction

endpackage

// ===== hw/rtl/barycentric_from_dot_products.sv =====
// Top level of the barycentric weight pipeline: front end, Gram stage,
// divider and the output register. Depends on bfd_pkg and the bfd_* modules.
//
// Channel query: one word holds vertices a, b, c and the point, 16-bit
// signed coordinates. Accepted on a clock edge with query_valid high and
// query_stall low.
// Channel weights: one word per query with weight_a/b/c (signed, 16
// fraction bits, saturated to -8.0 .. 8.0-lsb) and the degenerate flag,
// which is set with all weights zero when the Gram determinant is zero.
// Taken on an edge with weights_valid high and weights_stall low.
// Stages from acceptance to weights_valid: 3 dot-product stages, 3 Gram
// stages, 21 divider stages and one output register.
// Throughput: one query per cycle unless weights_stall holds the output; the
// divider's 20 steps are 20 stages, one quotient bit per step after the first.
// When weights_stall is high the result holds and the pipeline keeps
// filling its empty stages; query_stall rises only once every stage is full.
// Reset clears all valid bits; no result is presented until a query runs
// through.
module barycentric_from_dot_products (
	input  logic          clk,
	input  logic          arst_n,
	input  bfd_pkg::in_t  query,
	input  logic          query_valid,
	output logic          query_stall,
	output bfd_pkg::out_t weights,
	output logic          weights_valid,
	input  logic          weights_stall
);
	import bfd_pkg::*;

	dots_t dots;
	gram_t gram;
	quot_t quot;
	logic  front_en, gram_en, div_en, out_en;
	logic  dots_valid, gram_valid, quot_valid;
	out_t  res_q;
	logic  valid_q;
	logic signed [WEIGHT_BITS-1:0] wb, wc;
	logic signed [WEIGHT_BITS+1:0] wa_sum;
	logic signed [WEIGHT_BITS-1:0] wa;

	bfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query),
		.in_valid  (query_valid),
		.in_en     (front_en),
		.dots      (dots),
		.out_valid (dots_valid),
		.out_en    (gram_en)
	);

	bfd_gram u_gram (
		.clk       (clk),
		.arst_n    (arst_n),
		.dots      (dots),
		.in_valid  (dots_valid),
		.in_en     (gram_en),
		.gram      (gram),
		.out_valid (gram_valid),
		.out_en    (div_en)
	);

	bfd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.gram      (gram),
		.in_valid  (gram_valid),
		.in_en     (div_en),
		.quot      (quot),
		.out_valid (quot_valid),
		.out_en    (out_en)
	);

	assign query_stall = !front_en;
	assign out_en      = !valid_q || !weights_stall;

	always_comb begin
		if (quot.satb) wb = quot.negb ? W_MIN : W_MAX;
		else           wb = quot.negb ? -WEIGHT_BITS'(quot.qb) : WEIGHT_BITS'(quot.qb);
		if (quot.satc) wc = quot.negc ? W_MIN : W_MAX;
		else           wc = quot.negc ? -WEIGHT_BITS'(quot.qc) : WEIGHT_BITS'(quot.qc);
		wa_sum = (WEIGHT_BITS+2)'(W_ONE) - (WEIGHT_BITS+2)'(wb) - (WEIGHT_BITS+2)'(wc);
		if (wa_sum > (WEIGHT_BITS+2)'(W_MAX))      wa = W_MAX;
		else if (wa_sum < (WEIGHT_BITS+2)'(W_MIN)) wa = W_MIN;
		else                                       wa = WEIGHT_BITS'(wa_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (out_en) valid_q <= quot_valid;
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			if (quot.degen) begin
				res_q.weight_a <= '0;
				res_q.weight_b <= '0;
				res_q.weight_c <= '0;
			end else begin
				res_q.weight_a <= wa;
				res_q.weight_b <= wb;
				res_q.weight_c <= wc;
			end
			res_q.degenerate <= quot.degen;
		end
	end

	assign weights       = res_q;
	assign weights_valid = valid_q;

	// the input side only backs up when the output word is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		query_stall |-> (weights_valid && weights_stall))
		else $error("query stalled while output free");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(weights_valid && weights.degenerate) |->
		(weights.weight_a == '0 && weights.weight_b == '0 && weights.weight_c == '0))
		else $error("degenerate word carries non-zero weights");

	// a taken word must make room at the output register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(weights_valid && !weights_stall && !quot_valid) |=> !weights_valid)
		else $error("output word repeated");

endmodule

// ===== hw/rtl/bfd_front.sv =====
// Front end: edge vectors, products and the five dot products (3 stages).
// Depends on bfd_pkg.
module bfd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  bfd_pkg::in_t  query,
	input  logic          in_valid,
	output logic          in_en,
	output bfd_pkg::dots_t dots,
	output logic          out_valid,
	input  logic          out_en
);
	import bfd_pkg::*;

	logic signed [COORD_BITS-1:0] va[3], vb[3], vc[3], vp[3];
	logic signed [EDGE_W-1:0] e0_s1[3], e1_s1[3], e2_s1[3];
	logic signed [PROD_W-1:0] pr_s2[5][3];
	dots_t dots_s3;
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign va[0] = query.vert_a_x; assign va[1] = query.vert_a_y; assign va[2] = query.vert_a_z;
	assign vb[0] = query.vert_b_x; assign vb[1] = query.vert_b_y; assign vb[2] = query.vert_b_z;
	assign vc[0] = query.vert_c_x; assign vc[1] = query.vert_c_y; assign vc[2] = query.vert_c_z;
	assign vp[0] = query.point_x;  assign vp[1] = query.point_y;  assign vp[2] = query.point_z;

	// advance a stage when it is empty or the next one moves
	assign en3   = !v_s3 || out_en;
	assign en2   = !v_s2 || en3;
	assign en1   = !v_s1 || en2;
	assign in_en = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 3; i++) begin
				e0_s1[i] <= EDGE_W'(vb[i]) - EDGE_W'(va[i]);
				e1_s1[i] <= EDGE_W'(vc[i]) - EDGE_W'(va[i]);
				e2_s1[i] <= EDGE_W'(vp[i]) - EDGE_W'(va[i]);
			end
		end
		if (en2) begin
			for (int i = 0; i < 3; i++) begin
				pr_s2[0][i] <= e0_s1[i] * e0_s1[i];
				pr_s2[1][i] <= e0_s1[i] * e1_s1[i];
				pr_s2[2][i] <= e1_s1[i] * e1_s1[i];
				pr_s2[3][i] <= e2_s1[i] * e0_s1[i];
				pr_s2[4][i] <= e2_s1[i] * e1_s1[i];
			end
		end
		if (en3) begin
			dots_s3.d00 <= DOT_W'(pr_s2[0][0]) + DOT_W'(pr_s2[0][1]) + DOT_W'(pr_s2[0][2]);
			dots_s3.d01 <= DOT_W'(pr_s2[1][0]) + DOT_W'(pr_s2[1][1]) + DOT_W'(pr_s2[1][2]);
			dots_s3.d11 <= DOT_W'(pr_s2[2][0]) + DOT_W'(pr_s2[2][1]) + DOT_W'(pr_s2[2][2]);
			dots_s3.d20 <= DOT_W'(pr_s2[3][0]) + DOT_W'(pr_s2[3][1]) + DOT_W'(pr_s2[3][2]);
			dots_s3.d21 <= DOT_W'(pr_s2[4][0]) + DOT_W'(pr_s2[4][1]) + DOT_W'(pr_s2[4][2]);
		end
	end

	assign dots      = dots_s3;
	assign out_valid = v_s3;

endmodule

// ===== hw/rtl/bfd_gram.sv =====
// Gram determinant and the two cofactors from split 36x36 multiplies
// (partial products, join, subtract: 3 stages). Depends on bfd_pkg.
module bfd_gram (
	input  logic            clk,
	input  logic            arst_n,
	input  bfd_pkg::dots_t  dots,
	input  logic            in_valid,
	output logic            in_en,
	output bfd_pkg::gram_t  gram,
	output logic            out_valid,
	input  logic            out_en
);
	import bfd_pkg::*;

	pp4_t pp_s4[6];
	logic signed [MUL_W-1:0] m_s5[6];
	gram_t gram_s6;
	logic v_s4, v_s5, v_s6;
	logic en4, en5, en6;

	assign en6   = !v_s6 || out_en;
	assign en5   = !v_s5 || en6;
	assign en4   = !v_s4 || en5;
	assign in_en = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en4) v_s4 <= in_valid;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			pp_s4[0] <= part_mul(dots.d00, dots.d11);
			pp_s4[1] <= part_mul(dots.d01, dots.d01);
			pp_s4[2] <= part_mul(dots.d11, dots.d20);
			pp_s4[3] <= part_mul(dots.d01, dots.d21);
			pp_s4[4] <= part_mul(dots.d00, dots.d21);
			pp_s4[5] <= part_mul(dots.d01, dots.d20);
		end
		if (en5) begin
			for (int i = 0; i < 6; i++)
				m_s5[i] <= join_mul(pp_s4[i]);
		end
		if (en6) begin
			gram_s6.den <= GRAM_W'(m_s5[0]) - GRAM_W'(m_s5[1]);
			gram_s6.nb  <= GRAM_W'(m_s5[2]) - GRAM_W'(m_s5[3]);
			gram_s6.nc  <= GRAM_W'(m_s5[4]) - GRAM_W'(m_s5[5]);
		end
	end

	assign gram      = gram_s6;
	assign out_valid = v_s6;

endmodule

// ===== hw/rtl/bfd_div.sv =====
// Twin restoring divider sharing the divisor, one quotient bit per integer or fraction step:
// sign/magnitude stage, overflow check, 3 integer and FRAC_BITS fraction steps.
// Depends on bfd_pkg.
module bfd_div (
	input  logic            clk,
	input  logic            arst_n,
	input  bfd_pkg::gram_t  gram,
	input  logic            in_valid,
	output logic            in_en,
	output bfd_pkg::quot_t  quot,
	output logic            out_valid,
	input  logic            out_en
);
	import bfd_pkg::*;

	typedef struct packed {
		logic [REM_W-1:0] r;
		logic             hit;
	} step_t;

	function automatic step_t div_step(logic [REM_W-1:0] r, logic [GRAM_W-1:0] d,
			int unsigned k, logic shl);
		logic [REM_W-1:0] rs, ds;
		step_t o;
		rs    = shl ? (r << 1) : r;
		ds    = REM_W'(d) << k;
		o.hit = (rs >= ds);
		o.r   = o.hit ? (rs - ds) : rs;
		return o;
	endfunction

	function automatic logic [GRAM_W-1:0] mag(logic signed [GRAM_W-1:0] x);
		return x[GRAM_W-1] ? GRAM_W'(-x) : GRAM_W'(x);
	endfunction

	quot_t div_s[DIV_STEPS+1];
	logic  v_s[DIV_STEPS+1];
	logic  en[DIV_STEPS+1];

	assign en[DIV_STEPS] = !v_s[DIV_STEPS] || out_en;
	assign in_en         = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en[0]) v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			div_s[0].d     <= mag(gram.den);
			div_s[0].rb    <= REM_W'(mag(gram.nb));
			div_s[0].rc    <= REM_W'(mag(gram.nc));
			div_s[0].qb    <= '0;
			div_s[0].qc    <= '0;
			div_s[0].satb  <= 1'b0;
			div_s[0].satc  <= 1'b0;
			div_s[0].negb  <= gram.nb[GRAM_W-1] ^ gram.den[GRAM_W-1];
			div_s[0].negc  <= gram.nc[GRAM_W-1] ^ gram.den[GRAM_W-1];
			div_s[0].degen <= (gram.den == '0);
		end
	end

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		// first step only tests for a quotient of eight or more
		localparam int unsigned K   = (g == 0) ? 3 : ((g < 4) ? (3 - g) : 0);
		localparam logic        SHL = (g >= 4);
		step_t sb, sc;
		quot_t nx;

		assign en[g] = !v_s[g] || en[g+1];
		assign sb    = div_step(div_s[g].rb, div_s[g].d, K, SHL);
		assign sc    = div_step(div_s[g].rc, div_s[g].d, K, SHL);

		always_comb begin
			nx = div_s[g];
			if (g == 0) begin
				nx.satb = sb.hit;
				nx.satc = sc.hit;
			end else begin
				nx.rb = sb.r;
				nx.rc = sc.r;
				nx.qb = {div_s[g].qb[Q_W-2:0], sb.hit};
				nx.qc = {div_s[g].qc[Q_W-2:0], sc.hit};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[g+1] <= 1'b0;
			else if (en[g+1]) v_s[g+1] <= v_s[g];
		end

		always_ff @(posedge clk) begin
			if (en[g+1]) div_s[g+1] <= nx;
		end
	end

	assign quot      = div_s[DIV_STEPS];
	assign out_valid = v_s[DIV_STEPS];

endmodule
